FILE: hw/rtl/tlsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_pkg: shared types and constants of the two-list sorted merge
// Holds the list depth, derived widths, opcodes and the command type that
// travels from the front end through the queue to the merge engine.
// ----------------------------------------------------------------------------
package tlsm_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int TOT_W       = CNT_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_MERGE  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

endpackage

FILE: hw/rtl/tlsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_front: input stage and opcode classifier
// Registers each input transaction, decodes its opcode into a command and
// drops the unused opcode before it reaches the queue.
// ----------------------------------------------------------------------------
module tlsm_front
    import tlsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   i_s_tuser,   // [1:0] opcode
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_q_ready
);

    logic  r_valid;
    logic  n_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  dec_ok;
    t_kind dec_kind;

    always_comb begin
        dec_ok   = 1'b1;
        dec_kind = KIND_LOAD_A;
        unique case (i_s_tuser)
            OP_LOAD_A: dec_kind = KIND_LOAD_A;
            OP_LOAD_B: dec_kind = KIND_LOAD_B;
            OP_MERGE:  dec_kind = KIND_MERGE;
            default:   dec_ok   = 1'b0;
        endcase
    end

    assign o_s_tready = !r_valid || i_q_ready;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid && !i_q_ready;
        n_cmd   = r_cmd;
        if (i_s_tvalid && o_s_tready) begin
            // drop the unused opcode here
            n_valid     = dec_ok;
            n_cmd.kind  = dec_kind;
            n_cmd.value = i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

FILE: hw/rtl/tlsm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_queue: short command queue
// Decouples the front end from the merge engine so each side stalls alone.
// ----------------------------------------------------------------------------
module tlsm_queue
    import tlsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/tlsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_back: list storage and merge engine
// Executes loads into the two lists and walks both lists with two pointers
// on a merge, one result per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module tlsm_back
    import tlsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    output logic [1:0]        o_m_tuser
);

    logic [DATA_W-1:0] r_list_a [LIST_DEPTH];
    logic [DATA_W-1:0] r_list_b [LIST_DEPTH];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic [1:0]        r_out_user, n_out_user;

    logic              wr_a;
    logic              wr_b;
    logic              out_free;
    logic              a_ok;
    logic              b_ok;
    logic              take_a;
    logic [DATA_W-1:0] head_a;
    logic [DATA_W-1:0] head_b;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  emitted;

    assign head_a   = r_list_a[r_i[IDX_W-1:0]];
    assign head_b   = r_list_b[r_j[IDX_W-1:0]];
    assign a_ok     = (r_i < r_cnt_a);
    assign b_ok     = (r_j < r_cnt_b);
    assign take_a   = a_ok && (!b_ok || ($signed(head_a) <= $signed(head_b)));
    assign total    = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign emitted  = {1'b0, r_i} + {1'b0, r_j} + TOT_W'(1);
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;
        o_q_pop     = 1'b0;
        wr_a        = 1'b0;
        wr_b        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.kind)
                        KIND_LOAD_A: begin
                            if (r_cnt_a < CNT_W'(LIST_DEPTH)) begin
                                wr_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        KIND_LOAD_B: begin
                            if (r_cnt_b < CNT_W'(LIST_DEPTH)) begin
                                wr_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        KIND_MERGE: begin
                            n_state = ST_MERGE;
                            n_i     = '0;
                            n_j     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (total == '0) begin
                        // both lists empty: one flagged zero result
                        n_out_data = '0;
                        n_out_last = 1'b1;
                        n_out_user = {r_ovf, 1'b1};
                    end else begin
                        n_out_data = take_a ? head_a : head_b;
                        n_out_last = (emitted == total);
                        n_out_user = {r_ovf, 1'b0};
                        if (take_a) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                    if (total == '0 || emitted == total) begin
                        n_state = ST_IDLE;
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
        if (wr_a) begin
            r_list_a[r_cnt_a[IDX_W-1:0]] <= i_q_cmd.value;
        end
        if (wr_b) begin
            r_list_b[r_cnt_b[IDX_W-1:0]] <= i_q_cmd.value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: hw/rtl/two_list_sorted_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_list_sorted_merge: two-way merge of two sorted lists
// Loads signed 32-bit values into list A or B and emits their ascending
// merge on a merge command.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser carries the opcode (load A, load B, merge; the
//   fourth code is dropped), tdata the value. Each list holds LIST_DEPTH
//   entries; loads into a full list are discarded and flag the next merge.
//   Master channel: tdata carries the merged value, tlast marks the final
//   result, tuser[0] flags an empty merge (both lists empty, value zero),
//   tuser[1] flags that a load was dropped since the previous merge.
//   Throughput: one load transaction per cycle while the queue has room;
//   a merge emits one result per cycle while the output register is free,
//   count_a + count_b results (one if both are empty), paced by the single
//   two-pointer compare in the engine. Loads that follow a merge wait in
//   the queue until its last result has entered the output register.
//   Path: a merge command passes the input register and the queue and sets
//   the engine's merge state; each result is held in the output register.
//   Reset clears both counts, the drop flag, the queue and the output
//   register; list contents are not cleared. A stalled receiver holds the
//   output register, the engine pauses and the queue backs up to the input.
// ----------------------------------------------------------------------------
module two_list_sorted_merge
    import tlsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   s_tuser,   // [1:0] opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] merged_value
    output logic              m_tlast,   // is_last
    output logic [1:0]        m_tuser    // [0] empty_res, [1] dropped
);

    // front end to queue
    logic push;
    t_cmd push_cmd;
    logic q_ready;

    // queue to merge engine
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // register and classify each input transaction
    tlsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_ready  (q_ready)
    );

    // buffer commands while the engine is busy merging
    tlsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // store loads and run the two-pointer merge
    tlsm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

endmodule

FILE: tb/sv/merge_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_result_checker: result prediction and comparison for the list merge
// Watches both stream channels, keeps its own copy of the two lists, the
// fill counts and the drop flag, predicts the results of every merge and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module merge_result_checker
    import tlsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   s_tuser,   // [1:0] opcode
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,   // [31:0] merged_value
    input  logic              m_tlast,   // is_last
    input  logic [1:0]        m_tuser,   // [0] empty_res, [1] dropped
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_checked
);

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     empty;
        logic                     dropped;
    } t_merge_result;

    logic signed [DATA_W-1:0] shadow_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] shadow_b [LIST_DEPTH];
    int unsigned              fill_a;
    int unsigned              fill_b;
    logic                     drop_seen;
    t_merge_result            expected_merge[$];

    // Update the list copies for one command; a merge queues its results.
    function automatic void predict_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        int unsigned   ia;
        int unsigned   ib;
        int unsigned   total;
        t_merge_result res;
        ia    = 0;
        ib    = 0;
        total = fill_a + fill_b;
        case (op)
            OP_LOAD_A: begin
                if (fill_a < LIST_DEPTH) begin
                    shadow_a[fill_a] = val;
                    fill_a++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            OP_LOAD_B: begin
                if (fill_b < LIST_DEPTH) begin
                    shadow_b[fill_b] = val;
                    fill_b++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            OP_MERGE: begin
                if (total == 0) begin
                    res = '{value: '0, last: 1'b1, empty: 1'b1, dropped: drop_seen};
                    expected_merge.push_back(res);
                end
                while (ia < fill_a || ib < fill_b) begin
                    // ties go to list A
                    if (ia < fill_a && (ib >= fill_b || shadow_a[ia] <= shadow_b[ib])) begin
                        res.value = shadow_a[ia];
                        ia++;
                    end else begin
                        res.value = shadow_b[ib];
                        ib++;
                    end
                    res.last    = (ia + ib == total);
                    res.empty   = 1'b0;
                    res.dropped = drop_seen;
                    expected_merge.push_back(res);
                end
                fill_a    = 0;
                fill_b    = 0;
                drop_seen = 1'b0;
            end
            default: begin
                // unused opcode: no state change
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_merge_result want;
        if (!i_rst_n) begin
            fill_a    = 0;
            fill_b    = 0;
            drop_seen = 1'b0;
            expected_merge.delete();
            o_mismatches  <= 0;
            o_checked     <= 0;
            o_outstanding <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_command(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_merge.size() == 0) begin
                    $display("%0t: unexpected result value %0d last %0b user %b",
                             $time, $signed(m_tdata), m_tlast, m_tuser);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_merge.pop_front();
                    o_checked <= o_checked + 1;
                    if (m_tdata !== want.value || m_tlast !== want.last ||
                        m_tuser[0] !== want.empty || m_tuser[1] !== want.dropped) begin
                        o_mismatches <= o_mismatches + 1;
                    end
                    if (m_tdata !== want.value) begin
                        $display("%0t: merged_value expected %0d actual %0d",
                                 $time, want.value, $signed(m_tdata));
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: is_last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                    end
                    if (m_tuser[0] !== want.empty) begin
                        $display("%0t: empty_res expected %0b actual %0b",
                                 $time, want.empty, m_tuser[0]);
                    end
                    if (m_tuser[1] !== want.dropped) begin
                        $display("%0t: dropped expected %0b actual %0b",
                                 $time, want.dropped, m_tuser[1]);
                    end
                end
            end
            o_outstanding <= expected_merge.size();
        end
    end

endmodule

FILE: tb/sv/two_list_sorted_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_list_sorted_merge_test: stimulus and verdict for the list merge
// Drives load and merge commands into the block with random gaps on both
// channels, one long receiver stall and a steady stretch without gaps; a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module two_list_sorted_merge_test
    import tlsm_pkg::*;
;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 280;
    localparam int LONG_STALL     = 250;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PERCENT   = 11;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // [31:0] value
    logic [OP_W-1:0]   s_tuser;   // [1:0] opcode
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // [31:0] merged_value
    logic              m_tlast;   // is_last
    logic [1:0]        m_tuser;   // [0] empty_res, [1] dropped

    int mismatches;
    int outstanding;
    int checked;

    // Stimulus-side bookkeeping; these only steer timing, never results.
    int  commands_sent;
    int  merges_sent;
    bit  steady_phase;
    int  stall_requests;
    int  stall_served;
    int  stall_left;
    int  cycle_count;

    two_list_sorted_merge dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    merge_result_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request so the
    // block fills up and stalls its input.
    initial begin
        m_tready     <= 1'b0;
        stall_served = 0;
        stall_left   = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (stall_served != stall_requests) begin
                stall_served++;
                stall_left = LONG_STALL - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Offer one command and hold it until the transaction completes.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        while (!steady_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op != OP_UNUSED) commands_sent++;
        if (op == OP_MERGE) merges_sent++;
        // keep one steady stretch with no gaps on either side
        steady_phase = (commands_sent >= 140 && commands_sent < 200);
    endtask

    function automatic int draw_value(input int mode);
        int v;
        case (mode)
            0: v = int'($urandom);
            1: v = int'($urandom_range(0, 15)) - 8;   // narrow range, many ties
            default: begin
                case ($urandom_range(0, 4))
                    0: v = int'(32'h8000_0000);
                    1: v = int'(32'h7fff_ffff);
                    2: v = 0;
                    3: v = -1;
                    default: v = int'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic int draw_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 5);
        if (r < 92) return $urandom_range(6, 16);
        return $urandom_range(17, 18);   // push past capacity
    endfunction

    // Load two ascending lists in random interleave, then merge.
    task automatic merge_lists(input int size_a, input int size_b);
        int vals_a[$];
        int vals_b[$];
        int mode;
        int ia;
        int ib;
        mode = $urandom_range(0, 2);
        for (int n = 0; n < size_a; n++) vals_a.push_back(draw_value(mode));
        for (int n = 0; n < size_b; n++) vals_b.push_back(draw_value(mode));
        vals_a.sort();
        vals_b.sort();
        ia = 0;
        ib = 0;
        while (ia < size_a || ib < size_b) begin
            if ($urandom_range(0, 99) < 4) send_cmd(OP_UNUSED, $urandom);
            if (ia < size_a && (ib >= size_b || $urandom_range(0, 1) == 0)) begin
                send_cmd(OP_LOAD_A, vals_a[ia]);
                ia++;
            end else begin
                send_cmd(OP_LOAD_B, vals_b[ib]);
                ib++;
            end
        end
        send_cmd(OP_MERGE, $urandom);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= OP_LOAD_A;
        commands_sent  = 0;
        merges_sent    = 0;
        steady_phase   = 1'b0;
        stall_requests = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: merge with both lists empty.
        send_cmd(OP_MERGE, '0);
        // Directed: extremes of the value range and a tie between A and B.
        send_cmd(OP_LOAD_A, 32'h8000_0000);
        send_cmd(OP_LOAD_A, 32'd5);
        send_cmd(OP_LOAD_B, 32'd5);
        send_cmd(OP_LOAD_B, 32'h7fff_ffff);
        send_cmd(OP_MERGE, 32'hffff_ffff);
        // Directed: unused opcode changes nothing, next merge is empty again.
        send_cmd(OP_UNUSED, 32'h1234_5678);
        send_cmd(OP_MERGE, '0);
        // Directed: overfill list A; the last load is dropped and flagged.
        for (int n = 0; n <= LIST_DEPTH; n++) send_cmd(OP_LOAD_A, 3 * n - 20);
        send_cmd(OP_MERGE, '0);

        // Full lists with a long receiver hold-off on the merge results;
        // the following commands back up into the input.
        for (int n = 0; n < LIST_DEPTH; n++) begin
            send_cmd(OP_LOAD_A, 2 * n);
            send_cmd(OP_LOAD_B, 2 * n + 1);
        end
        stall_requests++;
        send_cmd(OP_MERGE, '0);

        // Random: mostly well-formed list pairs, some raw noise.
        while (commands_sent < RANDOM_ITEMS - 20) begin
            if ($urandom_range(0, 99) < 80) begin
                merge_lists(draw_size(), draw_size());
            end else begin
                repeat ($urandom_range(1, 6)) send_cmd(OP_W'($urandom_range(0, 3)), $urandom);
            end
        end
        send_cmd(OP_MERGE, $urandom);   // flush whatever noise left loaded

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands, %0d merges, %0d results compared,",
                 commands_sent, merges_sent, checked);
        $display("including overfilled lists, empty merges and a long output stall.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
